### src/kmlpe_pkg.sv
package kmlpe_pkg;

   typedef enum logic {
      FUNC_SNAPSHOT   = 1'b0,
      FUNC_CONTROLLER = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      PROFILE_STANDARD  = 2'd0,
      PROFILE_REP_FIVE  = 2'd1,
      PROFILE_SOFT_KEYS = 2'd2,
      PROFILE_UNUSED    = 2'd3
   } profile_type;

   localparam logic [7:0]  CTRL_RELEASE = 8'h3c;
   localparam logic [7:0]  CTRL_SEIZE   = 8'h3d;

   localparam int          HOOK_BIT     = 19;
   localparam logic [31:0] HOOK_MASK    = 32'h0008_0000;
   localparam logic [31:0] REP_HI_MASK  = 32'h3e00_0000;
   localparam int          REP_FIRST    = 20;

   localparam logic [7:0]  NO_CODE      = 8'hff;
   localparam logic [7:0]  REP_BASE     = 8'h40;
   localparam logic [7:0]  SOFT_BASE    = 8'h90;
   localparam logic [3:0]  NO_DIGIT     = 4'hf;
   localparam logic [7:0]  PORT_RESET   = 8'hff;

   localparam int FN_COUNT    = 20;
   localparam int REP_COUNT   = 10;
   localparam int DIGIT_COUNT = 10;
   localparam int SOFT_COUNT  = 12;

   // matrix bit of each function and digit key, in priority order
   localparam logic [4:0] FN_BIT [FN_COUNT] = '{
      5'd0,  5'd1,  5'd2,  5'd3,  5'd4,  5'd5,  5'd6,  5'd7,
      5'd8,  5'd10, 5'd9,  5'd11, 5'd30, 5'd12, 5'd18,
      5'd13, 5'd14, 5'd15, 5'd16, 5'd17
   };

   localparam logic [7:0] FN_CODE [FN_COUNT] = '{
      8'h22, 8'h24, 8'h26, 8'h28, 8'h2a, 8'h2c, 8'h2e, 8'h30,
      8'h32, 8'h34, 8'h36, 8'h38,
      8'h20, 8'h58, 8'h5a,
      8'h3a, 8'h3c, 8'h3e,
      8'h56, 8'h54
   };

   // matrix bit of digits zero to nine
   localparam logic [4:0] DIGIT_BIT [DIGIT_COUNT] = '{
      5'd10, 5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8
   };

endpackage

### src/keypad_matrix_line_port_encoder.sv
// Keypad matrix and line port encoder.
// Input channel (req_*): req_func selects a key/line snapshot or a byte from
// the central controller. A snapshot is priority-encoded into a wire code and
// packed, with hook, line and host flags, into the port one and port two
// values; controller bytes release or seize the relay.
// Result channel (rsp_*): one result per input transfer, carrying the stored
// port values, the last wire code, hook and line bits, the no-service tone
// flag and the relay bit.
// Config channel (csr_*): the two-bit user io profile, always ready.
// Path: the input transfer is held in the input register, then the encoded
// result in the result register.
// Throughput: one item per cycle while rsp_ready holds, set by the single
// encode stage between the two registers.
// A stalled result holds in the result register while the input register
// still takes one more item; beyond that req_ready drops until rsp_ready.
// Reset clears both valid flags, the status bits and the profile, and sets
// the port values and wire code to 0xff.
module keypad_matrix_line_port_encoder (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [1:0]                csr_user_io_profile,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_func,
   input  logic [31:0]               req_key_matrix,
   input  logic [11:0]               req_soft_keys,
   input  logic [7:0]                req_line_control,
   input  logic                      req_out_of_service,
   input  logic                      req_voice_on,
   input  logic [7:0]                req_controller_byte,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [7:0]                rsp_port1_value,
   output logic [7:0]                rsp_port2_value,
   output logic [7:0]                rsp_wire_code,
   output logic                      rsp_hook_is_off,
   output logic                      rsp_line_is_ok,
   output logic                      rsp_tone_is_nis,
   output logic                      rsp_relay_held
);
   import kmlpe_pkg::*;

   profile_type profile_ff;

   logic        s0_valid_ff;
   func_type    s0_func_ff;
   logic [31:0] s0_matrix_ff;
   logic [11:0] s0_soft_ff;
   logic [7:0]  s0_line_ff;
   logic        s0_oos_ff;
   logic        s0_voice_ff;
   logic [7:0]  s0_byte_ff;

   logic        relay_ff, relay_in;
   logic        hook_ff, hook_in;
   logic        line_ok_ff, line_ok_in;
   logic        voice_ff, voice_in;
   logic        oos_ff, oos_in;
   logic [7:0]  port1_ff, port1_in;
   logic [7:0]  port2_ff, port2_in;
   logic [7:0]  code_ff, code_in;
   logic        tone_in;

   logic        rsp_valid_ff;
   logic [7:0]  rsp_port1_ff;
   logic [7:0]  rsp_port2_ff;
   logic [7:0]  rsp_code_ff;
   logic        rsp_hook_ff;
   logic        rsp_line_ff;
   logic        rsp_tone_ff;
   logic        rsp_relay_ff;

   logic        req_take;
   logic        s1_load;

   logic [31:0] keys;
   logic [11:0] soft_bits;
   logic        soft_single;
   logic [7:0]  key_code;
   logic [3:0]  digit;

   assign csr_ready = 1'b1;
   assign s1_load   = s0_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s0_valid_ff || s1_load;
   assign req_take  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         profile_ff <= PROFILE_STANDARD;
      end else if (csr_valid) begin
         profile_ff <= profile_type'(csr_user_io_profile);
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s0_func_ff   <= func_type'(req_func);
         s0_matrix_ff <= req_key_matrix;
         s0_soft_ff   <= req_soft_keys;
         s0_line_ff   <= req_line_control;
         s0_oos_ff    <= req_out_of_service;
         s0_voice_ff  <= req_voice_on;
         s0_byte_ff   <= req_controller_byte;
      end
   end

   // key priority: function and digit keys, then repertory, then soft keys
   always_comb begin
      keys = s0_matrix_ff & ~HOOK_MASK;
      if (profile_ff == PROFILE_REP_FIVE) begin
         keys = keys & ~REP_HI_MASK;
      end
      soft_bits   = s0_soft_ff;
      soft_single = (soft_bits != 12'd0) && ((soft_bits & (soft_bits - 12'd1)) == 12'd0);
      key_code    = NO_CODE;
      if (profile_ff == PROFILE_SOFT_KEYS && soft_single) begin
         for (int i = SOFT_COUNT - 1; i >= 0; i--) begin
            if (soft_bits[i]) begin
               key_code = SOFT_BASE | 8'(i);
            end
         end
      end
      for (int i = REP_COUNT - 1; i >= 0; i--) begin
         if (keys[REP_FIRST + i]) begin
            key_code = REP_BASE | 8'(2 * i);
         end
      end
      for (int i = FN_COUNT - 1; i >= 0; i--) begin
         if (keys[FN_BIT[i]]) begin
            key_code = FN_CODE[i];
         end
      end
   end

   // legacy digit path looks at the unmasked matrix
   always_comb begin
      digit = NO_DIGIT;
      for (int i = DIGIT_COUNT - 1; i >= 0; i--) begin
         if (s0_matrix_ff[DIGIT_BIT[i]]) begin
            digit = 4'(i);
         end
      end
   end

   always_comb begin
      relay_in   = relay_ff;
      hook_in    = hook_ff;
      line_ok_in = line_ok_ff;
      voice_in   = voice_ff;
      oos_in     = oos_ff;
      port1_in   = port1_ff;
      port2_in   = port2_ff;
      code_in    = code_ff;
      unique case (s0_func_ff)
         FUNC_SNAPSHOT: begin
            hook_in    = s0_matrix_ff[HOOK_BIT];
            line_ok_in = s0_line_ff[0];
            oos_in     = s0_oos_ff;
            voice_in   = s0_voice_ff;
            code_in    = key_code;
            if (key_code != NO_CODE) begin
               port1_in = {!hook_in, 1'b1, key_code[5:0]};
               port2_in = {s0_line_ff[7] | s0_voice_ff, s0_line_ff[6] | s0_oos_ff,
                           key_code[7:6], s0_line_ff[3:0]};
            end else begin
               port1_in = {!hook_in, 3'b000, digit};
               port2_in = {s0_voice_ff, s0_oos_ff, s0_line_ff[5:0]};
            end
         end
         FUNC_CONTROLLER: begin
            if (s0_byte_ff == CTRL_RELEASE) begin
               relay_in = 1'b0;
            end else if (s0_byte_ff == CTRL_SEIZE) begin
               relay_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
      tone_in = hook_in && !voice_in && oos_in && !relay_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         relay_ff   <= 1'b0;
         hook_ff    <= 1'b0;
         line_ok_ff <= 1'b0;
         voice_ff   <= 1'b0;
         oos_ff     <= 1'b0;
         port1_ff   <= PORT_RESET;
         port2_ff   <= PORT_RESET;
         code_ff    <= NO_CODE;
      end else if (s1_load) begin
         relay_ff   <= relay_in;
         hook_ff    <= hook_in;
         line_ok_ff <= line_ok_in;
         voice_ff   <= voice_in;
         oos_ff     <= oos_in;
         port1_ff   <= port1_in;
         port2_ff   <= port2_in;
         code_ff    <= code_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s1_load || (rsp_valid_ff && !rsp_ready);
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         rsp_port1_ff <= port1_in;
         rsp_port2_ff <= port2_in;
         rsp_code_ff  <= code_in;
         rsp_hook_ff  <= hook_in;
         rsp_line_ff  <= line_ok_in;
         rsp_tone_ff  <= tone_in;
         rsp_relay_ff <= relay_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_port1_value = rsp_port1_ff;
   assign rsp_port2_value = rsp_port2_ff;
   assign rsp_wire_code   = rsp_code_ff;
   assign rsp_hook_is_off = rsp_hook_ff;
   assign rsp_line_is_ok  = rsp_line_ff;
   assign rsp_tone_is_nis = rsp_tone_ff;
   assign rsp_relay_held  = rsp_relay_ff;

   // tone only while off hook and relay not seized
   a_tone_gated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_tone_is_nis && (rsp_relay_held || !rsp_hook_is_off)))
      else $error("tone flag set while on hook or relay seized");

   // a resolved wire code always sets port one bit 6
   a_code_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_wire_code != NO_CODE)) |-> rsp_port1_value[6])
      else $error("port one code flag disagrees with wire code");

   // port one bit 7 is the inverted hook state
   a_hook_bit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_port1_value[7] == !rsp_hook_is_off))
      else $error("port one hook bit disagrees with hook state");

   // a load of the result register never drops a held result
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !s1_load)
      else $error("result register overwritten while stalled");

endmodule

### tb/sv/keypad_port_checker.sv
`timescale 1ns / 1ps

module keypad_port_checker
   import kmlpe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_user_io_profile,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_func,
   input  logic [31:0] req_key_matrix,
   input  logic [11:0] req_soft_keys,
   input  logic [7:0]  req_line_control,
   input  logic        req_out_of_service,
   input  logic        req_voice_on,
   input  logic [7:0]  req_controller_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_port1_value,
   input  logic [7:0]  rsp_port2_value,
   input  logic [7:0]  rsp_wire_code,
   input  logic        rsp_hook_is_off,
   input  logic        rsp_line_is_ok,
   input  logic        rsp_tone_is_nis,
   input  logic        rsp_relay_held,
   output int          fail_count,
   output int          pending
);

   typedef struct packed {
      logic [7:0] port1;
      logic [7:0] port2;
      logic [7:0] code;
      logic       handset_up;
      logic       line_ok;
      logic       tone;
      logic       relay;
   } port_result_type;

   localparam logic [31:0] HANDSET_MASK = 32'h0008_0000;
   localparam logic [31:0] REP_SIX_UP   = 32'h3e00_0000;
   localparam int          DUE_DEPTH    = 16;

   // function and digit keys, highest priority first
   localparam int KEY_POS [20] = '{
      0, 1, 2, 3, 4, 5, 6, 7, 8, 10, 9, 11, 30, 12, 18, 13, 14, 15, 16, 17
   };
   localparam logic [7:0] KEY_CODE [20] = '{
      8'h22, 8'h24, 8'h26, 8'h28, 8'h2a, 8'h2c, 8'h2e, 8'h30, 8'h32, 8'h34,
      8'h36, 8'h38, 8'h20, 8'h58, 8'h5a, 8'h3a, 8'h3c, 8'h3e, 8'h56, 8'h54
   };
   localparam int DIGIT_POS [10] = '{10, 0, 1, 2, 3, 4, 5, 6, 7, 8};

   profile_type     profile;
   logic            relay_seized, handset_up, line_ok, voice, service_off;
   logic [7:0]      port1, port2, last_code;
   port_result_type results_due [DUE_DEPTH];
   int              due_head;
   int              due_tail;

   function automatic logic [7:0] wire_code_of(logic [31:0] matrix, logic [11:0] soft_bits,
                                                profile_type p);
      logic [31:0] keys;
      keys = matrix & ~HANDSET_MASK;
      if (p == PROFILE_REP_FIVE) keys = keys & ~REP_SIX_UP;
      for (int i = 0; i < 20; i++)
         if (keys[KEY_POS[i]]) return KEY_CODE[i];
      for (int i = 0; i < 10; i++)
         if (keys[20 + i]) return 8'h40 + 8'(2 * i);
      // soft key only counts when exactly one is down
      if (p == PROFILE_SOFT_KEYS && soft_bits != 12'h000 &&
          (soft_bits & (soft_bits - 12'h001)) == 12'h000)
         for (int i = 0; i < 12; i++)
            if (soft_bits[i]) return 8'h90 + 8'(i);
      return 8'hff;
   endfunction

   function automatic logic [3:0] digit_of(logic [31:0] matrix);
      for (int i = 0; i < 10; i++)
         if (matrix[DIGIT_POS[i]]) return 4'(i);
      return 4'hf;
   endfunction

   function automatic port_result_type encode_line_ports();
      port_result_type r;
      logic [7:0]      host;
      if (func_type'(req_func) == FUNC_SNAPSHOT) begin
         handset_up  = req_key_matrix[19];
         line_ok     = req_line_control[0];
         service_off = req_out_of_service;
         voice       = req_voice_on;
         host        = {voice, service_off, 6'b0};
         last_code   = wire_code_of(req_key_matrix, req_soft_keys, profile);
         if (last_code != 8'hff) begin
            port1 = {~handset_up, 1'b1, last_code[5:0]};
            port2 = (req_line_control & 8'hcf) | {2'b00, last_code[7:6], 4'b0000} | host;
         end else begin
            port1 = {~handset_up, 3'b000, digit_of(req_key_matrix)};
            port2 = (req_line_control & 8'h3f) | host;
         end
      end else if (req_controller_byte == CTRL_RELEASE) begin
         relay_seized = 1'b0;
      end else if (req_controller_byte == CTRL_SEIZE) begin
         relay_seized = 1'b1;
      end
      r.port1      = port1;
      r.port2      = port2;
      r.code       = last_code;
      r.handset_up = handset_up;
      r.line_ok    = line_ok;
      r.tone       = handset_up & ~voice & service_off & ~relay_seized;
      r.relay      = relay_seized;
      return r;
   endfunction

   task report_mismatch(string msg);
      $display("%0t: %s", $time, msg);
      fail_count++;
   endtask

   task check_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s is 0x%02h, predicted 0x%02h", name, got, want));
   endtask

   always @(posedge clock) begin
      port_result_type want;
      if (reset) begin
         profile      = PROFILE_STANDARD;
         relay_seized = 1'b0;
         handset_up   = 1'b0;
         line_ok      = 1'b0;
         voice        = 1'b0;
         service_off  = 1'b0;
         port1        = 8'hff;
         port2        = 8'hff;
         last_code    = 8'hff;
         fail_count   = 0;
         due_head     = 0;
         due_tail     = 0;
      end else begin
         if (csr_valid && csr_ready)
            profile = profile_type'(csr_user_io_profile);
         if (rsp_valid && rsp_ready) begin
            if (due_tail == due_head) begin
               report_mismatch("result transfer with nothing outstanding");
            end else begin
               want = results_due[due_head % DUE_DEPTH];
               due_head++;
               check_field("port1_value", rsp_port1_value, want.port1);
               check_field("port2_value", rsp_port2_value, want.port2);
               check_field("wire_code", rsp_wire_code, want.code);
               check_field("hook_is_off", 8'(rsp_hook_is_off), 8'(want.handset_up));
               check_field("line_is_ok", 8'(rsp_line_is_ok), 8'(want.line_ok));
               check_field("tone_is_nis", 8'(rsp_tone_is_nis), 8'(want.tone));
               check_field("relay_held", 8'(rsp_relay_held), 8'(want.relay));
            end
         end
         if (req_valid && req_ready) begin
            if (due_tail - due_head >= DUE_DEPTH) begin
               report_mismatch("too many results outstanding");
            end else begin
               results_due[due_tail % DUE_DEPTH] = encode_line_ports();
               due_tail++;
            end
         end
      end
      pending <= due_tail - due_head;
   end

endmodule

### tb/sv/tb_keypad_matrix_line_port_encoder.sv
`timescale 1ns / 1ps

module tb_keypad_matrix_line_port_encoder;
   import kmlpe_pkg::*;

   logic        clock;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_user_io_profile;
   logic        req_valid;
   logic        req_ready;
   logic        req_func;
   logic [31:0] req_key_matrix;
   logic [11:0] req_soft_keys;
   logic [7:0]  req_line_control;
   logic        req_out_of_service;
   logic        req_voice_on;
   logic [7:0]  req_controller_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_port1_value;
   logic [7:0]  rsp_port2_value;
   logic [7:0]  rsp_wire_code;
   logic        rsp_hook_is_off;
   logic        rsp_line_is_ok;
   logic        rsp_tone_is_nis;
   logic        rsp_relay_held;
   logic        steady;
   int          fail_count;
   int          pending;

   keypad_matrix_line_port_encoder dut (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_user_io_profile (csr_user_io_profile),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_func            (req_func),
      .req_key_matrix      (req_key_matrix),
      .req_soft_keys       (req_soft_keys),
      .req_line_control    (req_line_control),
      .req_out_of_service  (req_out_of_service),
      .req_voice_on        (req_voice_on),
      .req_controller_byte (req_controller_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_port1_value     (rsp_port1_value),
      .rsp_port2_value     (rsp_port2_value),
      .rsp_wire_code       (rsp_wire_code),
      .rsp_hook_is_off     (rsp_hook_is_off),
      .rsp_line_is_ok      (rsp_line_is_ok),
      .rsp_tone_is_nis     (rsp_tone_is_nis),
      .rsp_relay_held      (rsp_relay_held)
   );

   keypad_port_checker port_check (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_user_io_profile (csr_user_io_profile),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_func            (req_func),
      .req_key_matrix      (req_key_matrix),
      .req_soft_keys       (req_soft_keys),
      .req_line_control    (req_line_control),
      .req_out_of_service  (req_out_of_service),
      .req_voice_on        (req_voice_on),
      .req_controller_byte (req_controller_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_port1_value     (rsp_port1_value),
      .rsp_port2_value     (rsp_port2_value),
      .rsp_wire_code       (rsp_wire_code),
      .rsp_hook_is_off     (rsp_hook_is_off),
      .rsp_line_is_ok      (rsp_line_is_ok),
      .rsp_tone_is_nis     (rsp_tone_is_nis),
      .rsp_relay_held      (rsp_relay_held),
      .fail_count          (fail_count),
      .pending             (pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady || ($urandom_range(99) >= 15);
      end
   end

   task automatic send_item(func_type func, logic [31:0] matrix, logic [11:0] soft_bits,
                            logic [7:0] line, logic oos, logic voice, logic [7:0] ctrl_byte);
      if (!steady && $urandom_range(99) < 15) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_func            <= func;
      req_key_matrix      <= matrix;
      req_soft_keys       <= soft_bits;
      req_line_control    <= line;
      req_out_of_service  <= oos;
      req_voice_on        <= voice;
      req_controller_byte <= ctrl_byte;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic snapshot(logic [31:0] matrix, logic [11:0] soft_bits, logic [7:0] line,
                           logic oos, logic voice);
      send_item(FUNC_SNAPSHOT, matrix, soft_bits, line, oos, voice, 8'($urandom_range(255)));
   endtask

   // snapshot fields carry noise, they must be ignored
   task automatic controller(logic [7:0] ctrl_byte);
      send_item(FUNC_CONTROLLER, $urandom, 12'($urandom_range(4095)),
                8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                ctrl_byte);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic set_profile(profile_type p);
      drain();
      csr_valid           <= 1'b1;
      csr_user_io_profile <= p;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic random_item();
      logic [31:0] matrix;
      logic [11:0] soft_bits;
      logic [7:0]  ctrl_byte;
      if ($urandom_range(99) < 20) begin
         case ($urandom_range(4))
            0, 1:    ctrl_byte = CTRL_RELEASE;
            2, 3:    ctrl_byte = CTRL_SEIZE;
            default: ctrl_byte = 8'($urandom_range(255));
         endcase
         controller(ctrl_byte);
      end else begin
         // mostly sparse matrices so the lower priorities get reached
         case ($urandom_range(5))
            0:       matrix = $urandom & 32'h8008_0000;
            1:       matrix = (32'h1 << $urandom_range(31)) | ($urandom & 32'h0008_0000);
            2:       matrix = $urandom & 32'h3ff8_0000;
            3:       matrix = (32'h1 << $urandom_range(31)) | (32'h1 << $urandom_range(31));
            default: matrix = $urandom;
         endcase
         case ($urandom_range(4))
            0:       soft_bits = 12'h000;
            1:       soft_bits = 12'($urandom_range(4095));
            default: soft_bits = 12'h001 << $urandom_range(11);
         endcase
         snapshot(matrix, soft_bits, 8'($urandom_range(255)), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
      end
   endtask

   initial begin
      profile_type plan [8] = '{PROFILE_STANDARD, PROFILE_SOFT_KEYS, PROFILE_REP_FIVE,
                                PROFILE_UNUSED, PROFILE_SOFT_KEYS, PROFILE_STANDARD,
                                PROFILE_REP_FIVE, PROFILE_SOFT_KEYS};
      reset               = 1'b1;
      csr_valid           = 1'b0;
      csr_user_io_profile = PROFILE_STANDARD;
      req_valid           = 1'b0;
      req_func            = FUNC_SNAPSHOT;
      req_key_matrix      = '0;
      req_soft_keys       = '0;
      req_line_control    = '0;
      req_out_of_service  = 1'b0;
      req_voice_on        = 1'b0;
      req_controller_byte = '0;
      steady              = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // standard keypad straight out of reset
      snapshot(32'h0, 12'h000, 8'h00, 1'b0, 1'b0);
      snapshot(32'hffff_ffff, 12'hfff, 8'hff, 1'b1, 1'b1);
      snapshot(32'h0008_0000, 12'h000, 8'h01, 1'b1, 1'b0);
      controller(CTRL_SEIZE);
      controller(8'h00);
      controller(CTRL_RELEASE);
      controller(8'hff);
      snapshot(32'h0000_0600, 12'h000, 8'hfe, 1'b0, 1'b1);
      snapshot(32'h4000_0000, 12'h000, 8'h30, 1'b1, 1'b1);
      snapshot(32'h0004_0000, 12'h000, 8'hcf, 1'b0, 1'b0);
      snapshot(32'h0002_0000, 12'h000, 8'h0f, 1'b1, 1'b0);
      snapshot(32'h0010_0000, 12'h000, 8'h00, 1'b0, 1'b0);
      snapshot(32'h2000_0000, 12'h000, 8'hff, 1'b1, 1'b1);
      snapshot(32'h8000_0000, 12'h000, 8'h3f, 1'b0, 1'b1);
      snapshot(32'h0, 12'h001, 8'h80, 1'b0, 1'b0);

      set_profile(PROFILE_SOFT_KEYS);
      snapshot(32'h0, 12'h800, 8'hff, 1'b0, 1'b0);
      snapshot(32'h0, 12'h003, 8'h55, 1'b1, 1'b0);
      snapshot(32'h0008_0000, 12'h001, 8'haa, 1'b1, 1'b0);

      // repertory keys six to ten drop out
      set_profile(PROFILE_REP_FIVE);
      snapshot(32'h0200_0000, 12'h000, 8'h01, 1'b0, 1'b0);
      snapshot(32'h0100_0000, 12'h000, 8'h01, 1'b0, 1'b0);
      snapshot(32'hbe00_0000, 12'h000, 8'h00, 1'b1, 1'b1);

      set_profile(PROFILE_UNUSED);
      snapshot(32'h2000_0000, 12'h000, 8'h01, 1'b0, 1'b0);
      snapshot(32'h0, 12'h004, 8'h01, 1'b0, 1'b0);

      foreach (plan[ph]) begin
         set_profile(plan[ph]);
         steady <= (ph == 4);
         repeat (120) begin
            random_item();
            if ($urandom_range(199) == 0) drain();
         end
      end

      req_valid <= 1'b0;
      for (int w = 0; w < 2000 && pending != 0; w++) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### sim.f
src/kmlpe_pkg.sv
src/keypad_matrix_line_port_encoder.sv
tb/sv/keypad_port_checker.sv
tb/sv/tb_keypad_matrix_line_port_encoder.sv
